@@ rtl/core/mdwf_pkg.sv @@
// ----------------------------------------------------------------------------
// mdwf_pkg
// Shared constants, types and the raised-cosine table builder for the
// modulated delay (wow / flutter) block.
// ----------------------------------------------------------------------------
package mdwf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int PTR_BITS    = $clog2(STORE_DEPTH);
  localparam int SAMPLE_BITS = 24;
  localparam int COS_SIZE    = 1024;
  localparam int COS_BITS    = $clog2(COS_SIZE);
  localparam int H_BITS      = 17;

  localparam int DEPTH_BITS  = 16;
  localparam int STEP_BITS   = 28;
  localparam int SPREAD_BITS = 8;
  localparam int CFG_BITS    = 28;
  localparam int CFG_IDX_BITS = 2;

  localparam int MAC_A_BITS  = 33;
  localparam int MAC_B_BITS  = 29;
  localparam int MAC_P_BITS  = MAC_A_BITS + MAC_B_BITS;

  localparam logic [31:0] NOISE_SEED = 32'd987654321;
  localparam logic [DEPTH_BITS-1:0]  DEPTH_RESET  = 16'd128;
  localparam logic [STEP_BITS-1:0]   STEP_RESET   = 28'd681741;
  localparam logic [SPREAD_BITS-1:0] SPREAD_RESET = 8'd128;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DELAY_DEPTH   = 2'd0,
    REG_PHASE_STEP    = 2'd1,
    REG_RANDOM_SPREAD = 2'd2
  } reg_index_t;

  typedef logic [H_BITS-1:0] cos_t;
  typedef cos_t cos_rom_t [COS_SIZE];

  typedef struct packed {
    logic en;
    logic clr;
  } mac_cmd_t;

  typedef struct packed {
    logic                we;
    logic [PTR_BITS-1:0] waddr;
    logic [PTR_BITS-1:0] raddr;
  } store_ctl_t;

  // h = sin^2(pi*u/2^32) in Q1.16 via an integer sine polynomial
  function automatic cos_t cos_entry(int unsigned k);
    logic [63:0] u, a, t, t2, r, s, v;
    u = (64'(k) << (32 - COS_BITS)) & 64'hFFFF_FFFF;
    a = (u <= 64'h8000_0000) ? u : (64'h1_0000_0000 - u);
    t = (a * PI_Q30) >> 32;
    t2 = (t * t) >> 30;
    r = ONE_Q30;
    r = ONE_Q30 - ((t2 * r) >> 30) / 110;
    r = ONE_Q30 - ((t2 * r) >> 30) / 72;
    r = ONE_Q30 - ((t2 * r) >> 30) / 42;
    r = ONE_Q30 - ((t2 * r) >> 30) / 20;
    r = ONE_Q30 - ((t2 * r) >> 30) / 6;
    s = (t * r) >> 30;
    v = (s * s) >> 30;
    v = (v + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return H_BITS'(v);
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k < COS_SIZE; k++) begin
      rom[k] = cos_entry(k);
    end
    return rom;
  endfunction

endpackage

@@ rtl/core/mdwf_mac.sv @@
// ----------------------------------------------------------------------------
// mdwf_mac
// Shared signed multiply-accumulate unit, one product per cycle while enabled,
// into a registered accumulator.
// ----------------------------------------------------------------------------
module mdwf_mac (
  input  logic                                  clk,
  input  mdwf_pkg::mac_cmd_t                    cmd,
  input  logic signed [mdwf_pkg::MAC_A_BITS-1:0] a,
  input  logic signed [mdwf_pkg::MAC_B_BITS-1:0] b,
  output logic signed [mdwf_pkg::MAC_P_BITS-1:0] acc
);
  import mdwf_pkg::*;

  logic signed [MAC_P_BITS-1:0] prod;
  logic signed [MAC_P_BITS-1:0] base;

  assign prod = a * b;
  assign base = cmd.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      acc <= base + prod;
    end
  end

endmodule

@@ rtl/core/mdwf_store.sv @@
// ----------------------------------------------------------------------------
// mdwf_store
// Left and right circular sample stores with one write and one registered
// read port; entries never written read as zero.
// ----------------------------------------------------------------------------
module mdwf_store (
  input  logic                               clk,
  input  logic                               rst,
  input  mdwf_pkg::store_ctl_t               ctl,
  input  logic [mdwf_pkg::SAMPLE_BITS-1:0]   wr_left,
  input  logic [mdwf_pkg::SAMPLE_BITS-1:0]   wr_right,
  output logic [mdwf_pkg::SAMPLE_BITS-1:0]   rd_left,
  output logic [mdwf_pkg::SAMPLE_BITS-1:0]   rd_right
);
  import mdwf_pkg::*;

  logic [SAMPLE_BITS-1:0] left_mem  [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] right_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [SAMPLE_BITS-1:0] left_q;
  logic [SAMPLE_BITS-1:0] right_q;
  logic                   valid_q;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      left_mem[ctl.waddr]  <= wr_left;
      right_mem[ctl.waddr] <= wr_right;
    end
    left_q  <= left_mem[ctl.raddr];
    right_q <= right_mem[ctl.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl.we) begin
        valid[ctl.waddr] <= 1'b1;
      end
      valid_q <= valid[ctl.raddr];
    end
  end

  assign rd_left  = valid_q ? left_q  : '0;
  assign rd_right = valid_q ? right_q : '0;

endmodule

@@ rtl/core/mdwf_cos_rom.sv @@
// ----------------------------------------------------------------------------
// mdwf_cos_rom
// Raised-cosine lookup, Q1.16, registered read.
// ----------------------------------------------------------------------------
module mdwf_cos_rom (
  input  logic                          clk,
  input  logic [mdwf_pkg::COS_BITS-1:0] addr,
  output mdwf_pkg::cos_t                data
);
  import mdwf_pkg::*;

  localparam cos_rom_t COS_ROM = build_cos_rom();

  always_ff @(posedge clk) begin
    data <= COS_ROM[addr];
  end

endmodule

@@ rtl/core/modulated_delay_wow_flutter.sv @@
// ----------------------------------------------------------------------------
// modulated_delay_wow_flutter
// Stereo fractional delay line modulated by a raised-cosine oscillator with
// random rate fluctuation (tape wow / flutter).
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one stereo pair per request, m_* returns the delayed pair.
//   cfg_we / cfg_index / cfg_data write delay_depth (0), phase_step (1) and
//   random_spread (2); write only while no request is in flight.
//   A request is taken only while the sequencer is idle; s_tready drops on
//   acceptance and comes back once the pair is done, after the extra draw
//   steps when the oscillator phase wraps and a new fluctuation is drawn.
//   The pace is set by the shared multiply-accumulate unit: depth scaling,
//   four interpolation products, and two products for the new fluctuation.
//   The result is registered in the phase-update step. m_tdata sits in an
//   output register, so the next pair is taken while a result waits; if the
//   receiver is still stalled when the next result is ready the sequencer
//   holds until the register frees up.
//   Reset clears the stores (via valid bits, no sweep), write pointer, phase
//   and fluctuation, reseeds the noise generator and restores the register
//   defaults. Ready as soon as reset is released.
// ----------------------------------------------------------------------------
module modulated_delay_wow_flutter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [47:0]                       s_tdata,   // left_in (23:0), right_in (47:24)
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [47:0]                       m_tdata,   // left_out (23:0), right_out (47:24)
  input  logic                              cfg_we,
  input  logic [mdwf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mdwf_pkg::CFG_BITS-1:0]     cfg_data
);
  import mdwf_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_COS  = 10'b0000000010,
    ST_RDA  = 10'b0000000100,
    ST_RDB  = 10'b0000001000,
    ST_ML1  = 10'b0000010000,
    ST_MR0  = 10'b0000100000,
    ST_MR1  = 10'b0001000000,
    ST_PH   = 10'b0010000000,
    ST_N1   = 10'b0100000000,
    ST_N2   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [DEPTH_BITS-1:0]  delay_depth;
  logic [STEP_BITS-1:0]   phase_step;
  logic [SPREAD_BITS-1:0] random_spread;

  logic [PTR_BITS-1:0]    write_pointer;
  logic [31:0]            phase;
  logic signed [31:0]     fluct;
  logic [31:0]            noise;
  logic [31:0]            noise_next;

  logic [PTR_BITS-1:0]    dly;
  logic [15:0]            frac;
  logic [16:0]            wgt0;
  logic [PTR_BITS-1:0]    dly_now;
  logic [SAMPLE_BITS-1:0] right_a;
  logic [SAMPLE_BITS-1:0] right_b;
  logic [SAMPLE_BITS-1:0] left_res;

  logic                   accept;
  logic                   out_free;
  logic                   advance;
  logic signed [33:0]     phase_sum;
  logic                   wrap;

  mac_cmd_t                     mac_cmd;
  logic signed [MAC_A_BITS-1:0] mac_a;
  logic signed [MAC_B_BITS-1:0] mac_b;
  logic signed [MAC_P_BITS-1:0] acc;
  logic        [MAC_P_BITS-1:0] acc_rnd;

  store_ctl_t             st_ctl;
  logic [SAMPLE_BITS-1:0] rd_left;
  logic [SAMPLE_BITS-1:0] rd_right;
  cos_t                   cos_q;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;
  assign advance  = (state == ST_PH) && out_free;

  // xorshift32: 13 left, 17 right, 5 left
  always_comb begin
    noise_next = noise ^ (noise << 13);
    noise_next = noise_next ^ (noise_next >> 17);
    noise_next = noise_next ^ (noise_next << 5);
  end

  assign phase_sum = $signed({2'b00, phase}) + $signed({6'b0, phase_step})
                   + 34'(fluct);
  assign wrap      = (phase_sum[33:32] == 2'b01);

  // delay in Q8.16 is acc >> 8: integer part in bits 31:24
  assign dly_now = PTR_BITS'(acc[31:24]);
  assign wgt0    = 17'h10000 - {1'b0, frac};
  assign acc_rnd = acc + MAC_P_BITS'(32768);

  mdwf_cos_rom u_cos_rom (
    .clk  (clk),
    .addr (phase[31 -: COS_BITS]),
    .data (cos_q)
  );

  always_comb begin
    st_ctl.we    = accept;
    st_ctl.waddr = write_pointer;
    if (state == ST_RDA) begin
      st_ctl.raddr = write_pointer - dly_now;
    end else begin
      st_ctl.raddr = write_pointer - dly - PTR_BITS'(1);
    end
  end

  mdwf_store u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (st_ctl),
    .wr_left  (s_tdata[SAMPLE_BITS-1:0]),
    .wr_right (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  always_comb begin
    mac_cmd = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state)
      ST_COS: begin
        mac_cmd = '{en: 1'b1, clr: 1'b1};
        mac_a   = {{(MAC_A_BITS-H_BITS){1'b0}}, cos_q};
        mac_b   = {{(MAC_B_BITS-DEPTH_BITS){1'b0}}, delay_depth};
      end
      ST_RDB: begin
        mac_cmd = '{en: 1'b1, clr: 1'b1};
        mac_a   = {{(MAC_A_BITS-SAMPLE_BITS){rd_left[SAMPLE_BITS-1]}}, rd_left};
        mac_b   = {{(MAC_B_BITS-17){1'b0}}, wgt0};
      end
      ST_ML1: begin
        mac_cmd = '{en: 1'b1, clr: 1'b0};
        mac_a   = {{(MAC_A_BITS-SAMPLE_BITS){rd_left[SAMPLE_BITS-1]}}, rd_left};
        mac_b   = {{(MAC_B_BITS-16){1'b0}}, frac};
      end
      ST_MR0: begin
        mac_cmd = '{en: 1'b1, clr: 1'b1};
        mac_a   = {{(MAC_A_BITS-SAMPLE_BITS){right_a[SAMPLE_BITS-1]}}, right_a};
        mac_b   = {{(MAC_B_BITS-17){1'b0}}, wgt0};
      end
      ST_MR1: begin
        mac_cmd = '{en: 1'b1, clr: 1'b0};
        mac_a   = {{(MAC_A_BITS-SAMPLE_BITS){right_b[SAMPLE_BITS-1]}}, right_b};
        mac_b   = {{(MAC_B_BITS-16){1'b0}}, frac};
      end
      ST_PH: begin
        // start rnd * step on a wrap; right sum in acc is consumed this cycle
        mac_cmd = '{en: advance && wrap, clr: 1'b1};
        mac_a   = {noise_next[31], noise_next};
        mac_b   = {1'b0, phase_step};
      end
      ST_N1: begin
        // scaled = floor(rnd * step / 2^31)
        mac_cmd = '{en: 1'b1, clr: 1'b1};
        mac_a   = {{2{acc[MAC_P_BITS-1]}}, acc[MAC_P_BITS-1:31]};
        mac_b   = {{(MAC_B_BITS-SPREAD_BITS){1'b0}}, random_spread};
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  mdwf_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_COS;
      ST_COS:  state_next = ST_RDA;
      ST_RDA:  state_next = ST_RDB;
      ST_RDB:  state_next = ST_ML1;
      ST_ML1:  state_next = ST_MR0;
      ST_MR0:  state_next = ST_MR1;
      ST_MR1:  state_next = ST_PH;
      ST_PH: begin
        if (advance) begin
          state_next = wrap ? ST_N1 : ST_IDLE;
        end
      end
      ST_N1:   state_next = ST_N2;
      ST_N2:   state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      delay_depth   <= DEPTH_RESET;
      phase_step    <= STEP_RESET;
      random_spread <= SPREAD_RESET;
      write_pointer <= '0;
      phase         <= '0;
      fluct         <= '0;
      noise         <= NOISE_SEED;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_DELAY_DEPTH:   delay_depth   <= cfg_data[DEPTH_BITS-1:0];
          REG_PHASE_STEP:    phase_step    <= cfg_data[STEP_BITS-1:0];
          REG_RANDOM_SPREAD: random_spread <= cfg_data[SPREAD_BITS-1:0];
          default: ;
        endcase
      end
      if (advance) begin
        phase         <= phase_sum[31:0];
        write_pointer <= write_pointer + PTR_BITS'(1);
        if (wrap) begin
          noise <= noise_next;
        end
      end
      if (state == ST_N2) begin
        fluct <= acc[39:8];
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RDA) begin
      dly  <= dly_now;
      frac <= acc[23:8];
    end
    if (state == ST_RDB) begin
      right_a <= rd_right;
    end
    if (state == ST_ML1) begin
      right_b <= rd_right;
    end
    if (state == ST_MR0) begin
      left_res <= acc_rnd[16 +: SAMPLE_BITS];
    end
    if (advance) begin
      m_tdata <= {acc_rnd[16 +: SAMPLE_BITS], left_res};
    end
  end

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again right after a request");

  a_phase_moves_once: assert property (@(posedge clk) disable iff (rst)
    state != ST_PH |=> $stable(phase))
    else $error("oscillator phase changed outside the update step");

  a_fluct_on_draw: assert property (@(posedge clk) disable iff (rst)
    state != ST_N2 |=> $stable(fluct))
    else $error("fluctuation changed without a draw");

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_PH))
    else $error("result presented outside the update step");

endmodule

@@ bench/tb_modulated_delay_wow_flutter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modulated_delay_wow_flutter
// Streams stereo pairs through the modulated delay line and checks every
// returned pair against an in-bench model of the stores, the raised-cosine
// oscillator, the interpolation and the noise-driven rate fluctuation.
// Settings are changed between phases while the block is idle, both stream
// sides idle at random, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_modulated_delay_wow_flutter;

  localparam int HIST_LEN    = 256;
  localparam int COS_LEN     = 1024;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 12;

  localparam logic [63:0] HALF_TURN  = 64'h8000_0000;
  localparam logic [63:0] FULL_TURN  = 64'h1_0000_0000;
  localparam logic [63:0] PI_FIX     = 64'd3373259426;
  localparam logic [63:0] UNIT_FIX   = 64'd1073741824;
  localparam logic [15:0] DEPTH_MAX  = 16'd65024;
  localparam logic [27:0] STEP_MAX   = 28'hFFF_FFFF;
  localparam logic [7:0]  SPREAD_MAX = 8'd255;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_t;

  class delay_line_tracker;
    logic signed [23:0] left_hist [HIST_LEN];
    logic signed [23:0] right_hist [HIST_LEN];
    logic [16:0]        lift_rom [COS_LEN];
    logic [7:0]         wr_ptr;
    logic [31:0]        phase;
    longint             drift;
    logic [31:0]        noise;
    logic [15:0]        depth;
    logic [27:0]        step;
    logic [7:0]         spread;
    stereo_t            due_pairs [$];
    int                 faults;

    function new();
      for (int k = 0; k < COS_LEN; k++) begin
        lift_rom[k] = raised_cos(k);
      end
      for (int i = 0; i < HIST_LEN; i++) begin
        left_hist[i] = '0;
        right_hist[i] = '0;
      end
      wr_ptr = '0;
      phase = '0;
      drift = 0;
      noise = 32'd987654321;
      depth = 16'd128;
      step = 28'd681741;
      spread = 8'd128;
      faults = 0;
    endfunction

    // sin^2 of half the table angle, Q1.16, from a fixed-point sine series
    function logic [16:0] raised_cos(int k);
      logic [63:0] ang, fold, x, x2, series, sn, sq;
      int unsigned div [5];
      div = '{110, 72, 42, 20, 6};
      ang = 64'(k) << 22;
      fold = (ang <= HALF_TURN) ? ang : (FULL_TURN - ang);
      x = (fold * PI_FIX) >> 32;
      x2 = (x * x) >> 30;
      series = UNIT_FIX;
      foreach (div[j]) begin
        series = UNIT_FIX - ((x2 * series) >> 30) / div[j];
      end
      sn = (x * series) >> 30;
      sq = (sn * sn) >> 30;
      sq = (sq + 64'd8192) >> 14;
      if (sq > 64'd65536) begin
        sq = 64'd65536;
      end
      return sq[16:0];
    endfunction

    function logic signed [23:0] blend(logic signed [23:0] near_s, far_s, logic [15:0] frac);
      longint acc;
      acc = longint'(near_s) * (64'sd65536 - longint'(frac)) + longint'(far_s) * longint'(frac)
            + 64'sd32768;
      return 24'(acc >>> 16);
    endfunction

    function void set_reg(mdwf_pkg::reg_index_t which, logic [27:0] value);
      case (which)
        mdwf_pkg::REG_DELAY_DEPTH: depth = value[15:0];
        mdwf_pkg::REG_PHASE_STEP: step = value;
        mdwf_pkg::REG_RANDOM_SPREAD: spread = value[7:0];
        default: ;
      endcase
    endfunction

    // write the pair, tap the modulated delay, then advance the oscillator
    function void note_pair(logic signed [23:0] l, logic signed [23:0] r);
      longint tap, sum, scaled;
      logic [7:0] whole, p0, p1;
      logic [15:0] frac;
      int signed rnd;
      stereo_t e;
      tap = (longint'(depth) * longint'(lift_rom[phase[31:22]])) >> 8;
      whole = tap[23:16];
      frac = tap[15:0];
      p0 = wr_ptr - whole;
      p1 = wr_ptr - whole - 8'd1;
      left_hist[wr_ptr] = l;
      right_hist[wr_ptr] = r;
      e.left = blend(left_hist[p0], left_hist[p1], frac);
      e.right = blend(right_hist[p0], right_hist[p1], frac);
      due_pairs.push_back(e);

      sum = longint'(phase) + longint'(step) + drift;
      phase = sum[31:0];
      if (sum >= 64'sh1_0000_0000) begin
        noise = noise ^ (noise << 13);
        noise = noise ^ (noise >> 17);
        noise = noise ^ (noise << 5);
        rnd = signed'(noise);
        scaled = (longint'(rnd) * longint'(step)) >>> 31;
        drift = (scaled * longint'(spread)) >>> 8;
      end
      wr_ptr = wr_ptr + 8'd1;
    endfunction

    function void check_pair(logic signed [23:0] l, logic signed [23:0] r);
      stereo_t e;
      if (due_pairs.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected result: left %0d right %0d", l, r);
        end
      end else begin
        e = due_pairs.pop_front();
        if (e.left !== l || e.right !== r) begin
          faults++;
          if (faults <= 10) begin
            $display("mismatch: left expected %0d got %0d, right expected %0d got %0d",
                     e.left, l, e.right, r);
          end
        end
      end
    endfunction

    function int pending();
      return due_pairs.size();
    endfunction

    function int close_out();
      if (due_pairs.size() != 0) begin
        $display("%0d results never arrived", due_pairs.size());
        faults += due_pairs.size();
      end
      return faults;
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [47:0]                       s_tdata = '0;     // left_in (23:0), right_in (47:24)
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [47:0]                       m_tdata;          // left_out (23:0), right_out (47:24)
  logic                              cfg_we = 1'b0;
  logic [mdwf_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [mdwf_pkg::CFG_BITS-1:0]     cfg_data = '0;

  delay_line_tracker tracker = new();
  bit lazy_sink = 1'b1;
  bit hold_request = 1'b0;

  modulated_delay_wow_flutter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiving side: check results, stall in short bursts or one long hold
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        tracker.check_pair(m_tdata[23:0], m_tdata[47:24]);
      end
      if (stall_left == 0 && hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && lazy_sink && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", quiet);
        $display("** modulated_delay_wow_flutter: FAILED **");
        $finish;
      end
    end
  end

  task automatic offer_pair(input logic [23:0] l, input logic [23:0] r);
    s_tvalid <= 1'b1;
    s_tdata <= {r, l};
    do begin
      @(posedge clk);
    end while (!s_tready);
    tracker.note_pair(l, r);
  endtask

  task automatic drain_to_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic tune(input logic [15:0] dep, input logic [27:0] stp, input logic [7:0] spr);
    cfg_we <= 1'b1;
    cfg_index <= mdwf_pkg::REG_DELAY_DEPTH;
    cfg_data <= 28'(dep);
    @(posedge clk);
    cfg_index <= mdwf_pkg::REG_PHASE_STEP;
    cfg_data <= stp;
    @(posedge clk);
    cfg_index <= mdwf_pkg::REG_RANDOM_SPREAD;
    cfg_data <= 28'(spr);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(mdwf_pkg::REG_DELAY_DEPTH, 28'(dep));
    tracker.set_reg(mdwf_pkg::REG_PHASE_STEP, stp);
    tracker.set_reg(mdwf_pkg::REG_RANDOM_SPREAD, 28'(spr));
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'h00_0000;
      3: return 24'hFF_FFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int count, input bit gaps);
    for (int n = 0; n < count; n++) begin
      if (gaps && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      offer_pair(pick_sample(), pick_sample());
    end
  endtask

  initial begin : stimulus
    logic [15:0] dep;
    logic [27:0] stp;
    logic [7:0]  spr;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, field extremes and bit patterns
    offer_pair(24'h00_0000, 24'h00_0000);
    offer_pair(24'h7F_FFFF, 24'h80_0000);
    offer_pair(24'h80_0000, 24'h7F_FFFF);
    offer_pair(24'h55_5555, 24'hAA_AAAA);
    offer_pair(24'hAA_AAAA, 24'h55_5555);
    offer_pair(24'hFF_FFFF, 24'h00_0001);
    drain_to_idle();

    // deepest delay, fastest rate, widest spread: wraps and far taps
    tune(DEPTH_MAX, STEP_MAX, SPREAD_MAX);
    for (int n = 0; n < 16; n++) begin
      offer_pair(n[0] ? 24'h7F_FFFF : 24'h80_0000, n[1] ? 24'h80_0000 : 24'h7F_FFFF);
    end
    drain_to_idle();

    // base rate zero with the drawn drift still held, may run backward
    tune(16'd0, 28'd0, 8'd0);
    offer_pair(24'h12_3456, 24'hED_CBA9);
    offer_pair(24'h7F_FFFF, 24'h80_0000);
    offer_pair(24'h00_0000, 24'hFF_FFFF);
    drain_to_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: dep = 16'd0;
        1: dep = DEPTH_MAX;
        default: dep = 16'($urandom_range(0, 65024));
      endcase
      case ($urandom_range(0, 5))
        0: stp = 28'd0;
        1: stp = STEP_MAX;
        2, 3: stp = 28'($urandom_range(0, 1 << 22));
        default: stp = 28'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: spr = 8'd0;
        1: spr = SPREAD_MAX;
        default: spr = 8'($urandom);
      endcase
      if (ph == 4) begin
        dep = DEPTH_MAX;
        stp = STEP_MAX;
        spr = SPREAD_MAX;
      end else if (ph == 5) begin
        stp = 28'($urandom_range(0, 255));
      end
      tune(dep, stp, spr);
      lazy_sink = (ph != 9);
      if (ph == 2) begin
        hold_request = 1'b1;
      end
      run_phase(85, ph != 9);
      drain_to_idle();
    end

    repeat (20) @(posedge clk);
    if (tracker.close_out() == 0) begin
      $display("** modulated_delay_wow_flutter: PASSED **");
    end else begin
      $display("** modulated_delay_wow_flutter: FAILED **");
    end
    $finish;
  end

endmodule
